/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the calculator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  `ASSERT_CLK(label, !(expr), msg)

`endif

/* hdl/fcalc_pkg.sv */
// ----------------------------------------------------------------------------
// fcalc_pkg
// Types, key and operator codes, and constants for the calculator.
// ----------------------------------------------------------------------------
package fcalc_pkg;

  localparam int WORD_W      = 32;
  localparam int MAG_W       = 60;
  localparam int CNT_W       = 5;
  localparam int STEP_W      = 5;
  localparam int POW_IDX_W   = 4;
  localparam int NUM_POW     = 10;
  localparam int C_MAX_CHARS = 18;

  localparam logic [3:0] MAX_DIGIT = 4'd9;

  // key codes
  localparam logic [2:0] KEY_DIGIT  = 3'd0;
  localparam logic [2:0] KEY_CLEAR  = 3'd1;
  localparam logic [2:0] KEY_SIGN   = 3'd2;
  localparam logic [2:0] KEY_EQUALS = 3'd3;
  localparam logic [2:0] KEY_ADD    = 3'd4;
  localparam logic [2:0] KEY_SUB    = 3'd5;
  localparam logic [2:0] KEY_MUL    = 3'd6;
  localparam logic [2:0] KEY_DIV    = 3'd7;

  // pending operator codes
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV,
    ALU_CNT
  } alu_func_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [3:0] digit;
  } key_t;

  typedef struct packed {
    logic [MAG_W-1:0]         entry_magnitude;
    logic                     entry_negative;
    logic [CNT_W-1:0]         entry_digits;
    logic signed [WORD_W-1:0] accumulator;
    logic [2:0]               pending_op;
    logic                     entry_fresh;
  } disp_t;

  typedef struct packed {
    logic              start;
    alu_func_t         func;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] result;
  } alu_rsp_t;

  function automatic logic [WORD_W-1:0] pow10(input logic [POW_IDX_W-1:0] k);
    logic [WORD_W-1:0] p;
    case (k)
      4'd0:    p = 32'd1;
      4'd1:    p = 32'd10;
      4'd2:    p = 32'd100;
      4'd3:    p = 32'd1000;
      4'd4:    p = 32'd10000;
      4'd5:    p = 32'd100000;
      4'd6:    p = 32'd1000000;
      4'd7:    p = 32'd10000000;
      4'd8:    p = 32'd100000000;
      4'd9:    p = 32'd1000000000;
      default: p = '0;
    endcase
    return p;
  endfunction

  function automatic logic [2:0] key_to_op(input logic [2:0] key_code);
    logic [2:0] op;
    case (key_code)
      KEY_ADD: op = OP_ADD;
      KEY_SUB: op = OP_SUB;
      KEY_MUL: op = OP_MUL;
      KEY_DIV: op = OP_DIV;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

/* hdl/four_function_calculator_keys.sv */
// Digit, clear and sign keys give their result in the cycle after the request is taken.
// Equals or a chained operator runs the operation unless there is no operator or
// the divisor is zero (multiply/divide use the 32-step shared unit), then a
// 9-step decimal digit count on the same unit. One request at a time; the
// next is taken the cycle after the result is taken.
// Reset (rst, synchronous): display 0 with 1 digit, accumulator 0, no operator.
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// four_function_calculator_keys
// Immediate-execution calculator key handler with a sequenced shared ALU.
// ----------------------------------------------------------------------------
module four_function_calculator_keys #(
  parameter int MAX_CHARS = fcalc_pkg::C_MAX_CHARS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             key_valid,
  output logic             key_stall,
  input  fcalc_pkg::key_t  key,
  output logic             disp_valid,
  input  logic             disp_stall,
  output fcalc_pkg::disp_t disp
);
  import fcalc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CALC  = 5'b00010,
    S_SHOW  = 5'b00100,
    S_COUNT = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t            state;
  logic [MAG_W-1:0]  entry_value;
  logic              entry_sign;
  logic [CNT_W-1:0]  entry_count;
  logic [WORD_W-1:0] first_operand;
  logic [2:0]        operator_code;
  logic              fresh_flag;
  logic [WORD_W-1:0] result_word;
  logic [2:0]        new_op;
  logic              div_neg;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  logic              accept;
  logic [WORD_W-1:0] entry_word;
  logic [WORD_W-1:0] entry_mag;
  logic [WORD_W-1:0] first_mag;
  logic [WORD_W-1:0] result_mag;
  logic [WORD_W-1:0] quot_fixed;
  logic [MAG_W-1:0]  append_val;
  logic              room;
  logic              apply;
  logic              use_alu;
  logic [2:0]        key_op;

  fcalc_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  always_comb begin
    key_stall  = (state != S_IDLE);
    accept     = key_valid && !key_stall;
    entry_word = entry_sign ? (WORD_W'(0) - entry_value[WORD_W-1:0])
                            : entry_value[WORD_W-1:0];
    entry_mag  = entry_word[WORD_W-1] ? (WORD_W'(0) - entry_word) : entry_word;
    first_mag  = first_operand[WORD_W-1] ? (WORD_W'(0) - first_operand) : first_operand;
    result_mag = result_word[WORD_W-1] ? (WORD_W'(0) - result_word) : result_word;
    quot_fixed = div_neg ? (WORD_W'(0) - alu_rsp.result) : alu_rsp.result;
    append_val = (entry_value << 3) + (entry_value << 1) + MAG_W'(key.digit);
    room       = ((CNT_W+1)'(entry_count) + (CNT_W+1)'(entry_sign)) < (CNT_W+1)'(MAX_CHARS);
    key_op     = key_to_op(key.operation);
    apply      = (key.operation == KEY_EQUALS) ||
                 (operator_code != OP_NONE && !fresh_flag);
    // no-operator equals and divide by zero skip the arithmetic step
    use_alu    = (operator_code != OP_NONE) &&
                 !(operator_code == OP_DIV && entry_word == '0);

    alu_req.start = 1'b0;
    alu_req.func  = ALU_ADD;
    alu_req.a     = first_operand;
    alu_req.b     = entry_word;
    case (operator_code)
      OP_SUB: alu_req.func = ALU_SUB;
      OP_MUL: alu_req.func = ALU_MUL;
      OP_DIV: begin
        alu_req.func = ALU_DIV;
        alu_req.a    = first_mag;
        alu_req.b    = entry_mag;
      end
      default: ;
    endcase
    if (state == S_SHOW) begin
      alu_req.start = 1'b1;
      alu_req.func  = ALU_CNT;
      alu_req.a     = result_mag;
      alu_req.b     = '0;
    end else if (accept && (key.operation == KEY_EQUALS || key.operation[2]) &&
                 apply && use_alu) begin
      alu_req.start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      entry_value   <= '0;
      entry_sign    <= 1'b0;
      entry_count   <= CNT_W'(1);
      first_operand <= '0;
      operator_code <= OP_NONE;
      fresh_flag    <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (key.operation)
              KEY_DIGIT: begin
                if (key.digit <= MAX_DIGIT) begin
                  if (fresh_flag) begin
                    entry_value <= MAG_W'(key.digit);
                    entry_sign  <= 1'b0;
                    entry_count <= CNT_W'(1);
                    fresh_flag  <= 1'b0;
                  end else if (room) begin
                    entry_value <= append_val;
                    entry_count <= entry_count + CNT_W'(1);
                  end
                end
                state <= S_OUT;
              end
              KEY_CLEAR: begin
                entry_value   <= '0;
                entry_sign    <= 1'b0;
                entry_count   <= CNT_W'(1);
                first_operand <= '0;
                operator_code <= OP_NONE;
                fresh_flag    <= 1'b1;
                state         <= S_OUT;
              end
              KEY_SIGN: begin
                entry_sign <= ~entry_sign;
                state      <= S_OUT;
              end
              default: begin
                fresh_flag <= 1'b1;
                if (apply) begin
                  state <= use_alu ? S_CALC : S_SHOW;
                end else begin
                  first_operand <= entry_word;
                  operator_code <= key_op;
                  state         <= S_OUT;
                end
              end
            endcase
          end
        end
        S_CALC: begin
          if (alu_rsp.done) state <= S_SHOW;
        end
        S_SHOW: begin
          first_operand <= result_word;
          entry_sign    <= result_word[WORD_W-1];
          entry_value   <= MAG_W'(result_mag);
          operator_code <= new_op;
          state         <= S_COUNT;
        end
        S_COUNT: begin
          if (alu_rsp.done) begin
            entry_count <= alu_rsp.result[CNT_W-1:0];
            state       <= S_OUT;
          end
        end
        S_OUT: begin
          if (!disp_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      new_op      <= key_op;
      div_neg     <= first_operand[WORD_W-1] ^ entry_word[WORD_W-1];
      result_word <= (operator_code == OP_NONE) ? entry_word : '0;
    end else if (state == S_CALC && alu_rsp.done) begin
      result_word <= (operator_code == OP_DIV) ? quot_fixed : alu_rsp.result;
    end
  end

  always_comb begin
    disp_valid           = (state == S_OUT);
    disp.entry_magnitude = entry_value;
    disp.entry_negative  = entry_sign;
    disp.entry_digits    = entry_count;
    disp.accumulator     = signed'(first_operand);
    disp.pending_op      = operator_code;
    disp.entry_fresh     = fresh_flag;
  end

  `ASSERT_CLK(a_digits_range, disp_valid |-> (disp.entry_digits != '0 && disp.entry_digits <= CNT_W'(C_MAX_CHARS)), "digit count out of range")
  `ASSERT_CLK(a_done_expected, alu_rsp.done |-> (state == S_CALC || state == S_COUNT), "alu done outside a wait state")
  `ASSERT_CLK(a_op_range, disp_valid |-> (disp.pending_op <= OP_DIV), "bad pending operator")

endmodule

/* hdl/fcalc_alu.sv */
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// fcalc_alu
// Shared 32-bit add/subtract unit, stepped for shift-add multiply,
// restoring divide and decimal digit counting.
// ----------------------------------------------------------------------------
module fcalc_alu (
  input  logic               clk,
  input  logic               rst,
  input  fcalc_pkg::alu_req_t req,
  output fcalc_pkg::alu_rsp_t rsp
);
  import fcalc_pkg::*;

  logic              run;
  logic              done;
  alu_func_t         func;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] opb;
  logic [WORD_W-1:0] sh;
  logic [STEP_W-1:0] step;

  logic [WORD_W-1:0] add_x;
  logic [WORD_W-1:0] add_y;
  logic              add_sub;
  logic [WORD_W:0]   sum;
  logic [WORD_W-1:0] rem_shift;
  logic              last;

  always_comb begin
    rem_shift = {acc[WORD_W-2:0], sh[WORD_W-1]};
    add_x     = acc;
    add_y     = opb;
    add_sub   = 1'b0;
    if (!run) begin
      add_x   = req.a;
      add_y   = req.b;
      add_sub = (req.func == ALU_SUB);
    end else begin
      case (func)
        ALU_DIV: begin
          add_x   = rem_shift;
          add_sub = 1'b1;
        end
        ALU_CNT: begin
          add_y   = pow10(step[POW_IDX_W-1:0]);
          add_sub = 1'b1;
        end
        default: ;
      endcase
    end
    // carry out on subtract means x >= y
    sum = {1'b0, add_x} + {1'b0, add_y ^ {WORD_W{add_sub}}} + (WORD_W+1)'(add_sub);
    last = (func == ALU_CNT) ? (step == STEP_W'(NUM_POW - 1))
                             : (step == STEP_W'(WORD_W - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        case (req.func)
          ALU_MUL, ALU_DIV, ALU_CNT: run  <= 1'b1;
          default:                   done <= 1'b1;
        endcase
      end else if (run && last) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      func <= req.func;
      case (req.func)
        ALU_MUL: begin
          acc  <= '0;
          opb  <= req.a;
          sh   <= req.b;
          step <= '0;
        end
        ALU_DIV: begin
          acc  <= '0;
          opb  <= req.b;
          sh   <= req.a;
          step <= '0;
        end
        ALU_CNT: begin
          acc  <= req.a;
          sh   <= WORD_W'(1);
          step <= STEP_W'(1);
        end
        default: acc <= sum[WORD_W-1:0];
      endcase
    end else if (run) begin
      case (func)
        ALU_MUL: begin
          if (sh[0]) acc <= sum[WORD_W-1:0];
          sh  <= sh >> 1;
          opb <= opb << 1;
        end
        ALU_DIV: begin
          acc <= sum[WORD_W] ? sum[WORD_W-1:0] : rem_shift;
          sh  <= {sh[WORD_W-2:0], sum[WORD_W]};
        end
        ALU_CNT: begin
          if (sum[WORD_W]) sh <= WORD_W'(step) + WORD_W'(1);
        end
        default: ;
      endcase
      step <= step + STEP_W'(1);
    end
  end

  assign rsp.done   = done;
  assign rsp.result = (func == ALU_DIV || func == ALU_CNT) ? sh : acc;

  `ASSERT_NEVER(a_no_start_busy, run && req.start, "alu started while busy")
  `ASSERT_CLK(a_done_pulse, done |=> !done, "alu done longer than one cycle")
  `ASSERT_CLK(a_done_idle, done |-> !run, "alu busy while reporting done")

endmodule
